@@ rtl/sptx_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the SPI transmit packet ring allocator.
// No dependencies; every other file of the block imports this package.

package sptx_pkg;

    localparam int REQ_W    = 2;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 10;
    localparam int FRAME_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_LOAD     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISALIGN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QFULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOCONTIG = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd6;
    localparam logic [STATUS_W-1:0] ST_DMA_FAIL = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SIZE_W-1:0] packet_size;
        logic              dma_ok;
    } t_in_item;

    typedef struct packed {
        logic                accepted;
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  buffer_index;
        logic [SIZE_W-1:0]   packet_bytes;
        logic                chip_select;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

endpackage

@@ rtl/sptx_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer for the SPI transmit packet ring allocator.
// Depends on sptx_pkg for the command struct.

module sptx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sptx_pkg::t_cmd o_cmd
);
    import sptx_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result register must be empty or emptying before the
                // request changes any state.
                if (slot_free) begin
                    o_cmd.execute = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/sptx_dpath.sv @@
`timescale 1ns / 1ps
// Datapath of the SPI transmit packet ring allocator: ring pointers, byte
// counters, descriptor memory, request checks and the result register.
// Depends on sptx_pkg.

module sptx_dpath #(
    parameter int BUFFER_BYTES = 1024,
    parameter int QUEUE_DEPTH  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sptx_pkg::FRAME_W-1:0]   i_cfg_wdata,
    input  sptx_pkg::t_cmd                 i_cmd,
    input  sptx_pkg::t_in_item             i_in_data,
    output sptx_pkg::t_out_item            o_out_data
);
    import sptx_pkg::*;

    localparam int PW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [SW-1:0] BUF   = SW'(BUFFER_BYTES);
    localparam logic [NW-1:0] QD    = NW'(QUEUE_DEPTH);
    localparam logic [HW-1:0] QLAST = HW'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        TXN_IDLE   = 3'b001,
        TXN_ACTIVE = 3'b010,
        TXN_ERROR  = 3'b100
    } t_txn;

    // Remainder by three from the bit counts at even and odd places.
    function automatic logic mod3_nonzero(input logic [SIZE_W-1:0] x);
        logic [4:0] t;
        t = '0;
        for (int i = 0; i < SIZE_W; i++) begin
            t = t + (i % 2 == 0 ? 5'd1 : 5'd2) * {4'd0, x[i]};
        end
        if (t >= 5'd12) t = t - 5'd12;
        if (t >= 5'd6)  t = t - 5'd6;
        if (t >= 5'd3)  t = t - 5'd3;
        return (t != 5'd0);
    endfunction

    logic [FRAME_W-1:0] r_frame_bytes;
    t_in_item           r_req;
    logic [PW-1:0]      r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]      r_pend, n_pend, r_infl, n_infl;
    logic [HW-1:0]      r_head, n_head, r_tail, n_tail;
    logic [NW-1:0]      r_count, n_count;
    t_txn               r_txn, n_txn;
    t_out_item          r_out, n_out;

    logic [PW-1:0] r_mem_start [QUEUE_DEPTH];
    logic [CW-1:0] r_mem_size  [QUEUE_DEPTH];
    logic [PW-1:0] r_rd_start;
    logic [CW-1:0] r_rd_size;

    logic [SW-1:0] size_x, used, free_b, wp_x, rp_x, run_w, run_0;
    logic [SW-1:0] load_end, pop_end, start_x, pop_n, pend_x;
    logic          full, misalign, wrap, mem_we;
    logic [PW-1:0] start;
    logic [31:0]   idx_wide, bytes_wide;

    assign size_x = SW'(r_req.packet_size);
    assign used   = SW'(r_pend) + SW'(r_infl);
    assign full   = (used >= BUF);
    assign free_b = full ? '0 : BUF - used;
    assign wp_x   = SW'(r_wp);
    assign rp_x   = SW'(r_rp);
    assign run_w  = full ? '0 : ((wp_x < rp_x) ? rp_x - wp_x : BUF - wp_x);
    assign run_0  = full ? '0 : ((rp_x != '0) ? rp_x : BUF);
    assign start_x = SW'(start);
    assign load_end = start_x + size_x;
    assign pop_n    = SW'(r_rd_size);
    assign pop_end  = SW'(r_rd_start) + pop_n;
    assign pend_x   = SW'(r_pend);

    always_comb begin
        case (r_frame_bytes)
            2'd2:    misalign = r_req.packet_size[0];
            2'd3:    misalign = mod3_nonzero(r_req.packet_size);
            default: misalign = 1'b0;
        endcase
    end

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_pend  = r_pend;
        n_infl  = r_infl;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_txn   = r_txn;
        n_out   = r_out;
        wrap    = 1'b0;
        mem_we  = 1'b0;
        start   = r_wp;
        idx_wide   = '0;
        bytes_wide = '0;
        if (i_cmd.execute) begin
            n_out.accepted = 1'b0;
            n_out.status   = ST_OK;
            case (r_req.req_type)
                REQ_LOAD: begin
                    if (r_req.packet_size == '0 || misalign) begin
                        n_out.status = ST_MISALIGN;
                    end else if (r_count >= QD) begin
                        n_out.status = ST_QFULL;
                    end else if (size_x > free_b) begin
                        n_out.status = ST_NOSPACE;
                    end else if (size_x > run_w) begin
                        if (r_wp < r_rp) begin
                            n_out.status = ST_NOCONTIG;
                        end else begin
                            // Move to the ring start; the write position stays
                            // there even when the run at zero is too short.
                            wrap  = 1'b1;
                            start = '0;
                            if (size_x > run_0) begin
                                n_out.status = ST_NOCONTIG;
                            end
                        end
                    end
                    if (wrap) begin
                        n_wp = '0;
                    end
                    if (n_out.status == ST_OK) begin
                        mem_we         = 1'b1;
                        n_out.accepted = 1'b1;
                        n_tail  = (r_tail == QLAST) ? '0 : r_tail + 1'b1;
                        n_count = r_count + 1'b1;
                        n_wp    = (load_end == BUF) ? '0 : PW'(load_end);
                        n_pend  = CW'(pend_x + size_x);
                        idx_wide = 32'(start);
                    end
                end
                REQ_START: begin
                    if (r_infl != '0 || r_txn != TXN_IDLE) begin
                        n_out.status = ST_BUSY;
                    end else if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_head  = (r_head == QLAST) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_pend  = (pend_x >= pop_n) ? CW'(pend_x - pop_n) : '0;
                        n_rp    = (pop_end == BUF) ? '0 : PW'(pop_end);
                        if (r_req.dma_ok) begin
                            n_infl         = r_rd_size;
                            n_txn          = TXN_ACTIVE;
                            n_out.accepted = 1'b1;
                            idx_wide       = 32'(r_rd_start);
                            bytes_wide     = 32'(r_rd_size);
                        end else begin
                            n_infl       = '0;
                            n_txn        = TXN_ERROR;
                            n_out.status = ST_DMA_FAIL;
                        end
                    end
                end
                REQ_COMPLETE: begin
                    n_infl         = '0;
                    n_txn          = TXN_IDLE;
                    n_out.accepted = 1'b1;
                end
                default: begin
                end
            endcase
            n_out.buffer_index = idx_wide[INDEX_W-1:0];
            n_out.packet_bytes = bytes_wide[SIZE_W-1:0];
            n_out.chip_select  = (n_txn == TXN_ACTIVE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bytes <= FRAME_W'(1);
            r_wp    <= '0;
            r_rp    <= '0;
            r_pend  <= '0;
            r_infl  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_txn   <= TXN_IDLE;
        end else begin
            if (i_cfg_we) begin
                r_frame_bytes <= i_cfg_wdata;
            end
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_pend  <= n_pend;
            r_infl  <= n_infl;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_txn   <= n_txn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_data;
        end
        r_out <= n_out;
    end

    // Descriptor memory. The head entry is read every cycle, so it is ready
    // by the time a captured request executes; only an executing load writes.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_start[r_tail] <= start;
            r_mem_size[r_tail]  <= CW'(size_x);
        end
        r_rd_start <= r_mem_start[r_head];
        r_rd_size  <= r_mem_size[r_head];
    end

    assign o_out_data = r_out;

endmodule

@@ rtl/spi_tx_packet_ring_allocator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the SPI transmit packet ring allocator.
// Depends on sptx_pkg, sptx_ctrl and sptx_dpath.

// Each request (load, start next packet, transfer complete) yields exactly one
// result. A request is taken in the idle state and executed in the execute
// state, which waits for the output register; the controller handles one
// request at a time and the descriptor memory read of the queue head fills
// the time between. A finished result sits in the output register while the
// next request is taken, and execution waits only if that register is still
// full. The frame size register may be written whenever no request is in work.
// There is no clearing pass after reset.
module spi_tx_packet_ring_allocator_unit #(
    parameter int BUFFER_BYTES = 1024,
    parameter int QUEUE_DEPTH  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sptx_pkg::FRAME_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  sptx_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output sptx_pkg::t_out_item           o_out_data
);
    import sptx_pkg::*;

    t_cmd cmd;

    sptx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sptx_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data)
    );

endmodule
